FILE: hdl/bdq_pkg.sv
// Shared types and codes for the bounded double-ended queue.
package bdq_pkg;

    // Command codes carried in the operation field
    localparam logic [1:0] OP_PUSH_LEFT  = 2'd0;
    localparam logic [1:0] OP_PUSH_RIGHT = 2'd1;
    localparam logic [1:0] OP_POP_LEFT   = 2'd2;
    localparam logic [1:0] OP_POP_RIGHT  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // Register index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;

    localparam int          VALUE_W      = 32;
    localparam int          CAP_W        = 7;
    localparam logic [6:0]  CAP_RESET    = 7'd64;
    localparam int          TDATA_W      = 40;
    localparam int          GROUP_SIZE   = 8;

    // Sequencer states
    typedef enum logic
    {
        S_IDLE,
        S_GATHER
    } bdq_state_t;

    // Shift and load controls broadcast to every cell
    typedef struct packed
    {
        logic                      push_left;
        logic                      pop_left;
        logic                      push_right;
        logic signed [VALUE_W-1:0] value;
    } bdq_ctrl_t;

endpackage

FILE: hdl/bdq_cell.sv
// One storage cell of the queue chain: shifts with its neighbors or loads a new value.
module bdq_cell
(
    input  logic                               clk,
    input  bdq_pkg::bdq_ctrl_t                 ctrl,
    input  logic                               load_sel,
    input  logic                               tap_sel,
    input  logic signed [bdq_pkg::VALUE_W-1:0] left_in,
    input  logic signed [bdq_pkg::VALUE_W-1:0] right_in,
    output logic signed [bdq_pkg::VALUE_W-1:0] data,
    output logic signed [bdq_pkg::VALUE_W-1:0] tap
);
    import bdq_pkg::*;

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    // Push left moves everything one cell right, pop left one cell left
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push_left)
        begin
            data_next = left_in;
        end
        else if (ctrl.pop_left)
        begin
            data_next = right_in;
        end
        else if (ctrl.push_right && load_sel)
        begin
            data_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // Only the rightmost occupied cell drives the gather tree
    assign tap  = tap_sel ? data_reg : '0;

endmodule

FILE: hdl/bdq_gather.sv
// Registered OR tree that collects the rightmost entry from the cell taps.
module bdq_gather
#(
    parameter int DEPTH = 64
)
(
    input  logic                               clk,
    input  logic signed [bdq_pkg::VALUE_W-1:0] taps [DEPTH],
    output logic signed [bdq_pkg::VALUE_W-1:0] result
);
    import bdq_pkg::*;

    localparam int GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    logic signed [VALUE_W-1:0] group_or_reg  [GROUPS];
    logic signed [VALUE_W-1:0] group_or_next [GROUPS];

    // First level: OR of each group of cells
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_or_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < DEPTH)
                begin
                    group_or_next[g] = group_or_next[g] | taps[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_or_reg[g] <= group_or_next[g];
        end
    end

    // Second level: OR of the registered groups
    always_comb
    begin
        result = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            result = result | group_or_reg[g];
        end
    end

endmodule

FILE: hdl/bounded_double_ended_queue_core.sv
// Top level of the bounded double-ended queue: cell chain, control and APB register.
//
//  channel   | dir | handshake          | payload
//  s_        | in  | s_tvalid/s_tready  | s_tdata: operation[1:0], value[33:2]
//  m_        | out | m_tvalid/m_tready  | m_tdata: status[1:0], value_res[33:2]
//  APB       | in  | psel/penable       | capacity at byte address 0
//
//  Entries sit left-aligned in a chain of DEPTH cells; cell 0 is the left end.
//  Pushes and pop left answer from S_IDLE; a successful pop right also passes
//  through S_GATHER, where the registered OR tree picks out the rightmost cell.
//  A command is taken in S_IDLE while the result register is empty or being drained.
//  A stalled result blocks the input. Reset empties the queue and sets
//  capacity to 64; cell contents are not cleared.
module bounded_double_ended_queue_core
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], value[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], value_res[33:2], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CNT_W-1:0]          occ_reg;
    logic [CNT_W-1:0]          occ_next;
    logic [CAP_W-1:0]          cap_reg;
    bdq_state_t                state_reg;
    bdq_state_t                state_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [1:0]                out_status_reg;
    logic [1:0]                out_status_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [VALUE_W-1:0] out_value_next;

    logic [1:0]                op;
    logic signed [VALUE_W-1:0] in_value;
    logic                      in_fire;
    logic                      room;
    bdq_ctrl_t                 ctrl;
    logic signed [VALUE_W-1:0] cell_data [DEPTH];
    logic signed [VALUE_W-1:0] cell_tap  [DEPTH];
    logic signed [VALUE_W-1:0] gathered;

    assign op       = s_tdata[1:0];
    assign in_value = s_tdata[33:2];
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    // Room for a push: below capacity and below the chain length
    assign room = (CMP_W'(occ_reg) < CMP_W'(cap_reg)) && (occ_reg < CNT_W'(DEPTH));

    // Command decode, result and sequencing
    always_comb
    begin
        ctrl            = '0;
        ctrl.value      = in_value;
        occ_next        = occ_reg;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    case (op)
                        OP_PUSH_LEFT, OP_PUSH_RIGHT:
                        begin
                            if (room)
                            begin
                                ctrl.push_left  = (op == OP_PUSH_LEFT);
                                ctrl.push_right = (op == OP_PUSH_RIGHT);
                                occ_next        = occ_reg + CNT_W'(1);
                                out_status_next = ST_PUSHED;
                                out_value_next  = in_value;
                            end
                            else
                            begin
                                out_status_next = ST_FULL;
                            end
                        end
                        default:
                        begin
                            if (occ_reg == '0)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else if (op == OP_POP_LEFT)
                            begin
                                ctrl.pop_left   = 1'b1;
                                occ_next        = occ_reg - CNT_W'(1);
                                out_status_next = ST_POPPED;
                                out_value_next  = cell_data[0];
                            end
                            else
                            begin
                                // rightmost entry comes out of the tree next cycle
                                occ_next       = occ_reg - CNT_W'(1);
                                out_valid_next = 1'b0;
                                state_next     = S_GATHER;
                            end
                        end
                    endcase
                end
            end
            S_GATHER:
            begin
                out_valid_next  = 1'b1;
                out_status_next = ST_POPPED;
                out_value_next  = gathered;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_in;
        logic signed [VALUE_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = in_value;
        end
        else
        begin : g_inner_l
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_inner_r
            assign right_in = cell_data[i+1];
        end

        bdq_cell u_cell
        (
            .clk      (clk),
            .ctrl     (ctrl),
            .load_sel (occ_reg == CNT_W'(i)),
            .tap_sel  (occ_reg == CNT_W'(i + 1)),
            .left_in  (left_in),
            .right_in (right_in),
            .data     (cell_data[i]),
            .tap      (cell_tap[i])
        );
    end

    bdq_gather #(.DEPTH(DEPTH)) u_gather
    (
        .clk    (clk),
        .taps   (cell_tap),
        .result (gathered)
    );

    // Capacity register on the APB port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_reg} : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_value_reg, out_status_reg};

endmodule

FILE: hdl/bdq_checker.sv
// Port-level checks for the bounded double-ended queue, bound to the top level.
module bdq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import bdq_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // No new command while the result register is blocked
    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("command taken while result stalled");

    // Full and empty answers carry a zero value
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_FULL || m_tdata[1:0] == ST_EMPTY)
        |-> m_tdata[33:2] == 32'd0)
        else $error("nonzero value on full or empty");

endmodule

bind bounded_double_ended_queue_core bdq_checker u_bdq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/bdq_checker.sv
`timescale 1ns / 1ps
// Passive checker for the deque core: tracks capacity, predicts each answer, compares.
module bdq_scoreboard
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], value[33:2], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // status[1:0], value_res[33:2], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding
);
    import bdq_pkg::*;

    // Store depth of the core instance; pointers wrap naturally at 6 bits
    localparam int         DEPTH    = 64;
    localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
    localparam int         MAX_SHOWN = 10;

    typedef struct packed
    {
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
    } answer_t;

    // Shadow copy of the queue state
    logic [VALUE_W-1:0] slot_mem [DEPTH];
    logic [5:0]         left_free;
    logic [5:0]         right_free;
    logic [6:0]         held;
    logic [CAP_W-1:0]   cap_reg;

    answer_t answers [$];

    // Apply one command to the shadow queue and return its answer
    function automatic answer_t apply_command(input logic [1:0] op, input logic [VALUE_W-1:0] v);
        answer_t    r;
        logic [6:0] limit;
        limit   = (cap_reg > DEPTH) ? 7'(DEPTH) : cap_reg;
        r.value = '0;
        case (op)
            OP_PUSH_LEFT, OP_PUSH_RIGHT:
            begin
                if (held < limit)
                begin
                    if (op == OP_PUSH_LEFT)
                    begin
                        slot_mem[left_free] = v;
                        left_free = left_free - 6'd1;
                    end
                    else
                    begin
                        slot_mem[right_free] = v;
                        right_free = right_free + 6'd1;
                    end
                    held     = held + 7'd1;
                    r.status = ST_PUSHED;
                    r.value  = v;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            default:
            begin
                if (held == 7'd0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    if (op == OP_POP_LEFT)
                    begin
                        left_free = left_free + 6'd1;
                        r.value   = slot_mem[left_free];
                    end
                    else
                    begin
                        right_free = right_free - 6'd1;
                        r.value    = slot_mem[right_free];
                    end
                    held     = held - 7'd1;
                    r.status = ST_POPPED;
                end
            end
        endcase
        return r;
    endfunction

    // Watch register writes, command and answer transactions
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            cap_reg     = CAP_RESET;
            left_free   = 6'd0;
            right_free  = 6'd1;
            held        = 7'd0;
            answers.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
                cap_reg = pwdata[CAP_W-1:0];

            if (s_tvalid && s_tready)
                answers = {answers, apply_command(s_tdata[1:0], s_tdata[33:2])};

            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[1:0];
                got.value  = m_tdata[33:2];
                if (answers.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("unexpected answer: status %0d value %h", got.status, got.value);
                end
                else
                begin
                    want = answers.pop_front();
                    if (got.status != want.status || got.value != want.value)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                            $display("mismatch: expected status %0d value %h, got status %0d value %h",
                                     want.status, want.value, got.status, got.value);
                    end
                end
            end
            outstanding = answers.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the deque core: clock, reset, stimulus and verdict.
module tb_top;
    import bdq_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 119;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    int fail_count;
    int outstanding;

    bounded_double_ended_queue_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bdq_scoreboard i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at random
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("[bounded_double_ended_queue_core] ERROR");
            $finish;
        end
    end

    // Value mix with extra weight on the extremes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One command transaction; called and returns at a falling edge
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, val, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Wait until every answer is back and the core has settled
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // APB write of the capacity register
    task automatic write_capacity(input logic [6:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {25'b0, cap};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Bursts that lean toward pushes, toward pops, or neither
    task automatic run_random(input int n_items);
        int         done;
        int         burst;
        int         push_pct;
        int         k;
        logic [1:0] op;
        done = 0;
        while (done < n_items)
        begin
            burst = $urandom_range(80, 1);
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            for (k = 0; k < burst && done < n_items; k++)
            begin
                if ($urandom_range(99) < push_pct)
                    op = $urandom_range(1) ? OP_PUSH_RIGHT : OP_PUSH_LEFT;
                else
                    op = $urandom_range(1) ? OP_POP_RIGHT : OP_POP_LEFT;
                send_cmd(op, pick_value());
                done++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        int caps [PHASES];
        caps = '{64, 5, 127, 1, 40, 2, 64, 9};

        send_idle_pct = 31;
        recv_idle_pct = 60;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset capacity: empty pops, extreme values at both ends, drain
        send_cmd(OP_POP_LEFT,   32'h1234_5678);
        send_cmd(OP_POP_RIGHT,  32'h8765_4321);
        send_cmd(OP_PUSH_LEFT,  32'h8000_0000);
        send_cmd(OP_PUSH_RIGHT, 32'h7FFF_FFFF);
        send_cmd(OP_PUSH_LEFT,  32'h0000_0000);
        send_cmd(OP_PUSH_RIGHT, 32'hFFFF_FFFF);
        send_cmd(OP_POP_LEFT,   32'hFFFF_FFFF);
        send_cmd(OP_POP_RIGHT,  32'h0000_0000);
        send_cmd(OP_POP_RIGHT,  32'h5555_5555);
        send_cmd(OP_POP_LEFT,   32'hAAAA_AAAA);
        send_cmd(OP_POP_LEFT,   32'h0000_0001);

        // Capacity one: second push is full
        quiesce();
        write_capacity(7'd1);
        send_cmd(OP_PUSH_RIGHT, 32'h5555_5555);
        send_cmd(OP_PUSH_LEFT,  32'hAAAA_AAAA);
        send_cmd(OP_POP_LEFT,   32'h0);
        send_cmd(OP_POP_RIGHT,  32'h0);

        // Capacity zero: every push is full
        quiesce();
        write_capacity(7'd0);
        send_cmd(OP_PUSH_LEFT,  32'hDEAD_BEEF);
        send_cmd(OP_PUSH_RIGHT, 32'h0BAD_F00D);
        send_cmd(OP_POP_RIGHT,  32'h0);

        // Capacity above the store depth saturates
        quiesce();
        write_capacity(7'd127);
        send_cmd(OP_PUSH_LEFT,  32'h0000_0011);
        send_cmd(OP_PUSH_LEFT,  32'h0000_0022);
        send_cmd(OP_PUSH_RIGHT, 32'h0000_0033);
        send_cmd(OP_POP_RIGHT,  32'h0);
        send_cmd(OP_POP_RIGHT,  32'h0);
        send_cmd(OP_POP_RIGHT,  32'h0);

        // Random phases: receiver idle heavy, sender idle heavy, then no idling
        for (int p = 0; p < PHASES; p++)
        begin
            quiesce();
            if (p < 3)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 60;
            end
            else if (p < 6)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(caps[p][6:0]);
            run_random(PHASE_ITEMS);
        end

        quiesce();
        if (fail_count == 0)
            $display("[bounded_double_ended_queue_core] OK");
        else
            $display("[bounded_double_ended_queue_core] ERROR");
        $finish;
    end

endmodule
